FILE: hdl/bed_pkg.sv
// shared types, codes and helper functions for the button/encoder reporter
`timescale 1ns / 1ps

package bed_pkg;

  // widest button set the design supports
  localparam int MAX_BUTTONS = 16;

  // configuration register indexes
  localparam logic CFG_BUTTON_SETTLE  = 1'b0;
  localparam logic CFG_ENCODER_SETTLE = 1'b1;

  // command codes on the request byte
  localparam logic [7:0] REQ_NOP       = 8'd0;
  localparam logic [7:0] REQ_LOW_BYTE  = 8'd1;
  localparam logic [7:0] REQ_HIGH_BYTE = 8'd2;
  localparam logic [7:0] REQ_ENC_COUNT = 8'd3;
  localparam logic [7:0] REQ_CHECKSUM  = 8'd4;
  localparam logic [7:0] REQ_TEST      = 8'd5;
  localparam logic [7:0] REQ_APP       = 8'd6;
  localparam logic [7:0] REQ_BOOT1     = 8'd7;
  localparam logic [7:0] REQ_BOOT2     = 8'd8;

  // reply codes
  localparam logic [7:0] REPLY_NONE = 8'd0;
  localparam logic [7:0] REPLY_OK   = 8'd1;
  localparam logic [7:0] REPLY_FAIL = 8'd2;

  // debounced state seen by the command handler
  typedef struct packed {
    logic [MAX_BUTTONS-1:0] buttons;
    logic [7:0]             enc_count;
  } bed_status_t;

  // command handler result
  typedef struct packed {
    logic [7:0] reply;
    logic       boot;
    logic       enc_clear;
  } bed_cmd_res_t;

  // true when now is strictly later than the deadline, 16-bit wrap compare
  function automatic logic past_deadline(input logic [15:0] now,
                                         input logic [15:0] deadline);
    logic [15:0] diff;
    diff = deadline - now;
    return diff[15];
  endfunction

  // 2-bit gray code to binary
  function automatic logic [1:0] gray_to_binary(input logic [1:0] g);
    return {g[1], g[1] ^ g[0]};
  endfunction

endpackage

FILE: hdl/bed_button_lane.sv
// one button debounce lane: raw level, settle deadline, committed level
`timescale 1ns / 1ps

module bed_button_lane (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic [15:0] now,
  input  logic [14:0] settle_ticks,
  input  logic        pin_n,
  output logic        commit,
  output logic        level
);

  logic        raw_r, raw_nxt;
  logic        pending_r, pending_nxt;
  logic        deb_r, deb_nxt;
  logic [15:0] deadline_r, deadline_nxt;
  logic        changed;
  logic        pending_now;

  // restart the deadline on any change, then check it against this sample
  always_comb begin
    raw_nxt      = ~pin_n;
    changed      = raw_nxt ^ raw_r;
    deadline_nxt = changed ? (now + {1'b0, settle_ticks}) : deadline_r;
    pending_now  = pending_r | changed;
    commit       = en & pending_now & bed_pkg::past_deadline(now, deadline_nxt);
    deb_nxt      = commit ? raw_nxt : deb_r;
    pending_nxt  = pending_now & ~commit;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r     <= 1'b0;
      pending_r <= 1'b0;
      deb_r     <= 1'b0;
    end else if (en) begin
      raw_r     <= raw_nxt;
      pending_r <= pending_nxt;
      deb_r     <= deb_nxt;
    end
  end

  // deadline only matters while pending
  always_ff @(posedge clk) begin
    if (en) begin
      deadline_r <= deadline_nxt;
    end
  end

  assign level = deb_r;

endmodule

FILE: hdl/bed_encoder_lane.sv
// quadrature encoder lane: code debounce and signed step count
`timescale 1ns / 1ps

module bed_encoder_lane (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        clear,
  input  logic [15:0] now,
  input  logic [14:0] settle_ticks,
  input  logic        pin_a_n,
  input  logic        pin_b_n,
  output logic        commit,
  output logic [7:0]  count
);

  logic [1:0]  code_r, code_nxt;
  logic [1:0]  last_r, last_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] deadline_r, deadline_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        changed;
  logic        pending_now;
  logic        settled;
  logic [1:0]  cur_bin;
  logic [1:0]  prev_bin;

  // debounce the 2-bit code, then turn a single gray step into a count change
  always_comb begin
    code_nxt     = {~pin_b_n, ~pin_a_n};
    changed      = (code_nxt != code_r);
    deadline_nxt = changed ? (now + {1'b0, settle_ticks}) : deadline_r;
    pending_now  = pending_r | changed;
    settled      = en & pending_now & bed_pkg::past_deadline(now, deadline_nxt);
    cur_bin      = bed_pkg::gray_to_binary(code_nxt);
    prev_bin     = bed_pkg::gray_to_binary(last_r);
    pending_nxt  = pending_now & ~settled;
    last_nxt     = settled ? code_nxt : last_r;
    count_nxt    = count_r;
    commit       = 1'b0;
    if (settled) begin
      if (cur_bin == (prev_bin + 2'd1)) begin
        count_nxt = count_r - 8'd1;
        commit    = 1'b1;
      end else if (cur_bin == (prev_bin - 2'd1)) begin
        count_nxt = count_r + 8'd1;
        commit    = 1'b1;
      end
    end
  end

  // control state and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r    <= 2'd0;
      last_r    <= 2'd0;
      pending_r <= 1'b0;
      count_r   <= 8'd0;
    end else if (en) begin
      code_r    <= code_nxt;
      last_r    <= last_nxt;
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
    end else if (clear) begin
      count_r   <= 8'd0;
    end
  end

  // deadline only matters while pending
  always_ff @(posedge clk) begin
    if (en) begin
      deadline_r <= deadline_nxt;
    end
  end

  assign count = count_r;

endmodule

FILE: hdl/bed_cmd.sv
// command byte handler: reads, checksum and boot-entry handshake
`timescale 1ns / 1ps

module bed_cmd (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic [7:0]           req,
  input  bed_pkg::bed_status_t status,
  output bed_pkg::bed_cmd_res_t res
);

  logic [7:0] checksum_r, checksum_nxt;
  logic       armed_r, armed_nxt;

  // decode the command
  always_comb begin
    res          = '0;
    checksum_nxt = checksum_r;
    armed_nxt    = 1'b0;
    case (req)
      bed_pkg::REQ_BOOT1: begin
        res.reply    = bed_pkg::REPLY_OK;
        checksum_nxt = 8'd0;
        armed_nxt    = 1'b1;
      end
      bed_pkg::REQ_BOOT2: begin
        res.boot     = armed_r;
        res.reply    = armed_r ? bed_pkg::REPLY_NONE : bed_pkg::REPLY_FAIL;
        checksum_nxt = 8'd0;
      end
      bed_pkg::REQ_LOW_BYTE: begin
        res.reply    = status.buttons[7:0];
        checksum_nxt = checksum_r ^ status.buttons[7:0];
      end
      bed_pkg::REQ_HIGH_BYTE: begin
        res.reply    = status.buttons[15:8];
        checksum_nxt = checksum_r ^ status.buttons[15:8];
      end
      bed_pkg::REQ_ENC_COUNT: begin
        res.reply     = status.enc_count;
        res.enc_clear = 1'b1;
        checksum_nxt  = checksum_r ^ status.enc_count;
      end
      bed_pkg::REQ_CHECKSUM: begin
        res.reply    = ~checksum_r;
        checksum_nxt = 8'd0;
      end
      bed_pkg::REQ_TEST: begin
        res.reply    = bed_pkg::REPLY_OK;
        checksum_nxt = 8'd0;
      end
      default: begin
        res.reply    = bed_pkg::REPLY_NONE;
        checksum_nxt = 8'd0;
      end
    endcase
  end

  // checksum and handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_r <= 8'd0;
      armed_r    <= 1'b0;
    end else if (en) begin
      checksum_r <= checksum_nxt;
      armed_r    <= armed_nxt;
    end
  end

endmodule

FILE: hdl/button_encoder_debounce_spi_reporter.sv
// top level: button lanes, encoder lane, command handler and result register
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   in      | in_valid / in_stall  | command, button_pins, encoder pins, time,
//           |                      | request_byte
//   out     | out_valid / out_stall| reply_byte, change_irq, boot_request
//   cfg     | cfg_wr_en            | cfg_index, cfg_wdata
//
// One item per cycle unless stalled: every lane and the command decoder finish in the
// accept cycle, the result lands in a single output register in the cycle after.
// A new item is taken whenever the output register is empty or being drained.
// The critical path is the 16-bit deadline add and wrap compare in a lane.
// Synchronous active-low reset clears all debounce, count and handshake state
// and loads the settle registers with their defaults (1250 and 109 ticks).
`timescale 1ns / 1ps

module button_encoder_debounce_spi_reporter #(
  parameter int NUM_BUTTONS = 14
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_command,
  input  logic [NUM_BUTTONS-1:0] in_button_pins,
  input  logic                   in_encoder_pin_a,
  input  logic                   in_encoder_pin_b,
  input  logic [15:0]            in_sample_time,
  input  logic [7:0]             in_request_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_reply_byte,
  output logic                   out_change_irq,
  output logic                   out_boot_request,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_index,
  input  logic [14:0]            cfg_wdata
);

  logic [14:0]            button_settle_r;
  logic [14:0]            encoder_settle_r;
  logic                   in_xfer;
  logic                   pin_en;
  logic                   cmd_en;
  logic [NUM_BUTTONS-1:0] btn_commit;
  logic [NUM_BUTTONS-1:0] btn_level;
  logic                   enc_commit;
  logic [7:0]             enc_count;
  logic                   irq;
  bed_pkg::bed_status_t   status;
  bed_pkg::bed_cmd_res_t  cmd_res;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             reply_r;
  logic                   irq_r;
  logic                   boot_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_settle_r  <= 15'd1250;
      encoder_settle_r <= 15'd109;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bed_pkg::CFG_BUTTON_SETTLE:  button_settle_r  <= cfg_wdata;
        bed_pkg::CFG_ENCODER_SETTLE: encoder_settle_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input transfer steering
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign pin_en   = in_xfer & ~in_command;
  assign cmd_en   = in_xfer & in_command;

  // one debounce lane per button
  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    bed_button_lane u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .en           (pin_en),
      .now          (in_sample_time),
      .settle_ticks (button_settle_r),
      .pin_n        (in_button_pins[i]),
      .commit       (btn_commit[i]),
      .level        (btn_level[i])
    );
  end

  bed_encoder_lane u_enc (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (pin_en),
    .clear        (cmd_en & cmd_res.enc_clear),
    .now          (in_sample_time),
    .settle_ticks (encoder_settle_r),
    .pin_a_n      (in_encoder_pin_a),
    .pin_b_n      (in_encoder_pin_b),
    .commit       (enc_commit),
    .count        (enc_count)
  );

  // merge lane results
  assign irq              = (|btn_commit) | enc_commit;
  assign status.buttons   = bed_pkg::MAX_BUTTONS'(btn_level);
  assign status.enc_count = enc_count;

  bed_cmd u_cmd (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (cmd_en),
    .req    (in_request_byte),
    .status (status),
    .res    (cmd_res)
  );

  // output register
  assign out_valid_nxt = in_xfer | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      reply_r <= in_command ? cmd_res.reply : bed_pkg::REPLY_NONE;
      irq_r   <= ~in_command & irq;
      boot_r  <= in_command & cmd_res.boot;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reply_byte   = reply_r;
  assign out_change_irq   = irq_r;
  assign out_boot_request = boot_r;

  // a transfer in always leaves a result waiting
  a_xfer_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("accepted item produced no result");

  // a boot request carries a zero reply and no interrupt
  a_boot_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_boot_request |-> out_reply_byte == 8'd0 && !out_change_irq)
    else $error("boot request with reply or irq");

  // an interrupt only comes from a pin sample, which has no reply
  a_irq_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_change_irq |-> out_reply_byte == 8'd0)
    else $error("irq together with a reply");

  // lanes only commit on a pin sample transfer
  a_commit_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (|btn_commit) || enc_commit |-> pin_en)
    else $error("lane commit outside a pin sample");

endmodule
